@@ rtl/mea_pkg.sv @@
// Shared types and constants for the mouse event aggregator.
package mea_pkg;

    // Event modes carried by an input item.
    localparam logic [2:0] MODE_MOVE_X     = 3'd0;
    localparam logic [2:0] MODE_MOVE_Y     = 3'd1;
    localparam logic [2:0] MODE_WHEEL      = 3'd2;
    localparam logic [2:0] MODE_BUTTON     = 3'd3;
    localparam logic [2:0] MODE_FRAME      = 3'd4;
    localparam logic [2:0] MODE_DOWN_COUNT = 3'd5;
    localparam logic [2:0] MODE_UP_COUNT   = 3'd6;
    localparam logic [2:0] MODE_HELD_TIME  = 3'd7;

    // Result kinds.
    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_TOP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_RIGHT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_BOTTOM = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_MIN       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_MAX       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_STEP  = 3'd6;

    // A virtual wheel button is released this long after its press.
    localparam logic [31:0] WHEEL_RELEASE_MS = 32'd100;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] motion;
        logic [2:0]         button;
        logic               pressed;
        logic [31:0]        stamp_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic signed [15:0] delta_z;
        logic [7:0]         button_mask;
        logic [2:0]         event_button;
        logic               event_pressed;
        logic [31:0]        query_value;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_right;
        logic signed [15:0] rect_bottom;
        logic signed [15:0] z_min;
        logic signed [15:0] z_max;
        logic [14:0]        wheel_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rect_left:   16'sd0,
        rect_top:    16'sd0,
        rect_right:  16'sd640,
        rect_bottom: 16'sd480,
        z_min:       16'sd0,
        z_max:       16'sd1200,
        wheel_step:  15'd120
    };

    // Per-button statistics held in the button memory.
    typedef struct packed {
        logic [7:0]  press_count;
        logic [7:0]  release_count;
        logic [31:0] press_time;
        logic [31:0] release_time;
    } btn_entry_t;

endpackage

@@ rtl/mouse_event_aggregator.sv @@
// Top level of the mouse event aggregator: handshakes, configuration and output register.
// An item is registered into the execute stage, and its result into the output register before it is offered on m_.
// Throughput: one item per cycle while results are taken; each item makes one
// read-modify-write pass over the button statistics memory in the execute stage.
// Reset (aresetn low, synchronous) restores the configuration defaults and clears
// position, deltas, wheel accumulator, held bits and the memory entry valid bits.
module mouse_event_aggregator #(
    parameter int NUM_BUTTONS      = 8,
    parameter int NUM_REAL_BUTTONS = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mea_pkg::in_item_t                  s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mea_pkg::out_item_t                 m_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mea_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mea_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mea_pkg::*;

    localparam int ADDR_W = $clog2(NUM_BUTTONS);
    localparam logic [ADDR_W-1:0] UP_ADDR = ADDR_W'(NUM_REAL_BUTTONS);
    localparam logic [ADDR_W-1:0] DN_ADDR = ADDR_W'(NUM_REAL_BUTTONS + 1);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    in_item_t   s1_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    logic              s_accept;
    logic              s1_fire;
    logic              out_free;
    logic              has_result;
    out_item_t         result;
    logic [ADDR_W-1:0] rd_addr_a;
    btn_entry_t        entry_a;
    btn_entry_t        entry_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    btn_entry_t        wr_data;

    // Configuration registers, written at any time the port presents a transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RECT_LEFT:   cfg_reg.rect_left   <= $signed(cfg_data);
                REG_RECT_TOP:    cfg_reg.rect_top    <= $signed(cfg_data);
                REG_RECT_RIGHT:  cfg_reg.rect_right  <= $signed(cfg_data);
                REG_RECT_BOTTOM: cfg_reg.rect_bottom <= $signed(cfg_data);
                REG_Z_MIN:       cfg_reg.z_min       <= $signed(cfg_data);
                REG_Z_MAX:       cfg_reg.z_max       <= $signed(cfg_data);
                REG_WHEEL_STEP:  cfg_reg.wheel_step  <= cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control: the execute stage commits when its result has room.
    assign out_free = !out_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && (!has_result || out_free);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= s_item;
        end
    end

    // Wheel items read both virtual wheel entries; others read their own button.
    assign rd_addr_a = (s_item.mode == MODE_WHEEL) ? UP_ADDR : ADDR_W'(s_item.button);

    mea_btn_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (DN_ADDR),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_data_a (entry_a),
        .rd_data_b (entry_b)
    );

    mea_exec #(
        .NUM_BUTTONS      (NUM_BUTTONS),
        .NUM_REAL_BUTTONS (NUM_REAL_BUTTONS),
        .ADDR_W           (ADDR_W)
    ) u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (s1_fire),
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .entry_a    (entry_a),
        .entry_b    (entry_b),
        .has_result (has_result),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // Output register decouples the result channel from the execute stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && has_result) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // A result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && has_result) |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

    // The memory is written only by a committing item.
    a_write_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> s1_fire)
        else $error("button memory written without a committing item");

    // A stalled item stays in the execute stage.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stalled item lost from execute stage");

    // A committed result is offered on the next cycle.
    a_result_offered: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && has_result) |=> m_valid)
        else $error("committed result not offered");

endmodule

@@ rtl/mea_btn_store.sv @@
// Button statistics memory with two read ports, one write port and write forwarding.
module mea_btn_store #(
    parameter int ADDR_W = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr_a,
    input  logic [ADDR_W-1:0]      rd_addr_b,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  mea_pkg::btn_entry_t    wr_data,
    output mea_pkg::btn_entry_t    rd_data_a,
    output mea_pkg::btn_entry_t    rd_data_b
);
    import mea_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    btn_entry_t        mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;

    btn_entry_t rd_a_reg;
    btn_entry_t rd_b_reg;
    btn_entry_t fwd_data_reg;
    logic       hit_a_reg;
    logic       hit_b_reg;
    logic       live_a_reg;
    logic       live_b_reg;

    // Memory array: one write and two registered reads per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // Entries never written read as zero, which stands in for the reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_en) begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // Capture a write that lands on the same edge as the read, so it can be forwarded.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hit_a_reg    <= wr_en && (wr_addr == rd_addr_a);
            hit_b_reg    <= wr_en && (wr_addr == rd_addr_b);
            live_a_reg   <= written_reg[rd_addr_a];
            live_b_reg   <= written_reg[rd_addr_b];
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data_a = hit_a_reg ? fwd_data_reg : (live_a_reg ? rd_a_reg : '0);
    assign rd_data_b = hit_b_reg ? fwd_data_reg : (live_b_reg ? rd_b_reg : '0);

endmodule

@@ rtl/mea_exec.sv @@
// Execute stage: motion state, held bits, clamping and button memory updates.
module mea_exec #(
    parameter int NUM_BUTTONS      = 8,
    parameter int NUM_REAL_BUTTONS = 4,
    parameter int ADDR_W           = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  mea_pkg::in_item_t      item,
    input  mea_pkg::cfg_t          cfg,
    input  mea_pkg::btn_entry_t    entry_a,
    input  mea_pkg::btn_entry_t    entry_b,
    output logic                   has_result,
    output mea_pkg::out_item_t     result,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output mea_pkg::btn_entry_t    wr_data
);
    import mea_pkg::*;

    localparam int HELD_W = 2 ** ADDR_W;
    localparam bit UP_OK  = NUM_REAL_BUTTONS < NUM_BUTTONS;
    localparam bit DN_OK  = (NUM_REAL_BUTTONS + 1) < NUM_BUTTONS;
    localparam logic [ADDR_W-1:0] UP_ADDR = ADDR_W'(NUM_REAL_BUTTONS);
    localparam logic [ADDR_W-1:0] DN_ADDR = ADDR_W'(NUM_REAL_BUTTONS + 1);
    localparam int MASK_N = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;

    logic signed [15:0] pos_x_reg,   pos_x_next;
    logic signed [15:0] pos_y_reg,   pos_y_next;
    logic signed [15:0] pos_z_reg,   pos_z_next;
    logic signed [15:0] delta_x_reg, delta_x_next;
    logic signed [15:0] delta_y_reg, delta_y_next;
    logic signed [15:0] delta_z_reg, delta_z_next;
    logic signed [15:0] accum_reg,   accum_next;
    logic [HELD_W-1:0]  held_reg,    held_next;

    logic [ADDR_W-1:0]  btn_addr;
    logic               btn_held;
    logic               real_ok;
    logic               query_ok;
    logic signed [15:0] acc_sum;
    logic signed [16:0] acc_ext;
    logic signed [16:0] step_ext;
    logic               wheel_up;
    logic               wheel_dn;
    logic signed [15:0] x_low, y_low, z_high;
    logic signed [15:0] clamp_x, clamp_y, clamp_z;
    logic [7:0]         mask;
    logic               wr_req;

    // A wheel press bumps both counts and stamps a press and a later release.
    function automatic btn_entry_t wheel_bump(input btn_entry_t e, input logic [31:0] stamp);
        btn_entry_t r;
        r.press_count   = e.press_count + 8'd1;
        r.release_count = e.release_count + 8'd1;
        r.press_time    = stamp;
        r.release_time  = stamp + WHEEL_RELEASE_MS;
        return r;
    endfunction

    // Button decode.
    assign btn_addr = ADDR_W'(item.button);
    assign btn_held = held_reg[btn_addr];
    assign real_ok  = (int'(item.button) < NUM_REAL_BUTTONS) && (int'(item.button) < NUM_BUTTONS);
    assign query_ok = int'(item.button) < NUM_BUTTONS;

    // Wheel accumulator threshold compare.
    assign acc_sum  = accum_reg + item.motion;
    assign acc_ext  = {acc_sum[15], acc_sum};
    assign step_ext = $signed({2'b00, cfg.wheel_step});
    assign wheel_up = acc_ext >= step_ext;
    assign wheel_dn = !wheel_up && (acc_ext <= -step_ext);

    // Frame clamping: x and y raised then lowered, z lowered then raised.
    assign x_low   = (pos_x_reg < cfg.rect_left) ? cfg.rect_left : pos_x_reg;
    assign clamp_x = (x_low >= cfg.rect_right) ? (cfg.rect_right - 16'sd1) : x_low;
    assign y_low   = (pos_y_reg < cfg.rect_top) ? cfg.rect_top : pos_y_reg;
    assign clamp_y = (y_low >= cfg.rect_bottom) ? (cfg.rect_bottom - 16'sd1) : y_low;
    assign z_high  = (pos_z_reg > cfg.z_max) ? cfg.z_max : pos_z_reg;
    assign clamp_z = (z_high < cfg.z_min) ? cfg.z_min : z_high;

    // Held mask over the first eight buttons, or over all of them when there are fewer.
    always_comb begin
        mask = '0;
        for (int i = 0; i < MASK_N; i++) begin
            mask[i] = held_reg[i];
        end
    end

    // Per-mode update of state, memory write and result.
    always_comb begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        pos_z_next   = pos_z_reg;
        delta_x_next = delta_x_reg;
        delta_y_next = delta_y_reg;
        delta_z_next = delta_z_reg;
        accum_next   = accum_reg;
        held_next    = held_reg;
        result       = '0;
        has_result   = 1'b0;
        wr_req       = 1'b0;
        wr_addr      = btn_addr;
        wr_data      = entry_a;

        unique case (item.mode) inside
            MODE_MOVE_X: begin
                pos_x_next   = pos_x_reg + item.motion;
                delta_x_next = delta_x_reg + item.motion;
            end
            MODE_MOVE_Y: begin
                pos_y_next   = pos_y_reg + item.motion;
                delta_y_next = delta_y_reg + item.motion;
            end
            MODE_WHEEL: begin
                pos_z_next   = pos_z_reg + item.motion;
                delta_z_next = delta_z_reg + item.motion;
                accum_next   = acc_sum;
                if (wheel_up) begin
                    accum_next = '0;
                    if (UP_OK) begin
                        wr_req             = 1'b1;
                        wr_addr            = UP_ADDR;
                        wr_data            = wheel_bump(entry_a, item.stamp_ms);
                        held_next[UP_ADDR] = 1'b1;
                    end
                end else if (wheel_dn) begin
                    accum_next = '0;
                    if (DN_OK) begin
                        wr_req             = 1'b1;
                        wr_addr            = DN_ADDR;
                        wr_data            = wheel_bump(entry_b, item.stamp_ms);
                        held_next[DN_ADDR] = 1'b1;
                    end
                end
            end
            MODE_BUTTON: begin
                if (real_ok && (item.pressed != btn_held)) begin
                    wr_req              = 1'b1;
                    held_next[btn_addr] = item.pressed;
                    if (item.pressed) begin
                        wr_data.press_count = entry_a.press_count + 8'd1;
                        wr_data.press_time  = item.stamp_ms;
                    end else begin
                        wr_data.release_count = entry_a.release_count + 8'd1;
                        wr_data.release_time  = item.stamp_ms;
                    end
                    has_result           = 1'b1;
                    result.kind          = KIND_BUTTON;
                    result.event_button  = item.button;
                    result.event_pressed = item.pressed;
                end
            end
            MODE_FRAME: begin
                if (UP_OK) begin
                    held_next[UP_ADDR] = 1'b0;
                end
                if (DN_OK) begin
                    held_next[DN_ADDR] = 1'b0;
                end
                pos_x_next         = clamp_x;
                pos_y_next         = clamp_y;
                pos_z_next         = clamp_z;
                delta_x_next       = '0;
                delta_y_next       = '0;
                delta_z_next       = '0;
                has_result         = 1'b1;
                result.kind        = KIND_FRAME;
                result.pos_x       = clamp_x;
                result.pos_y       = clamp_y;
                result.pos_z       = clamp_z;
                result.delta_x     = delta_x_reg;
                result.delta_y     = delta_y_reg;
                result.delta_z     = delta_z_reg;
                result.button_mask = mask;
            end
            MODE_DOWN_COUNT, MODE_UP_COUNT, MODE_HELD_TIME: begin
                has_result          = 1'b1;
                result.kind         = KIND_QUERY;
                result.event_button = item.button;
                if (query_ok) begin
                    wr_req = 1'b1;
                    if (item.mode == MODE_DOWN_COUNT) begin
                        result.query_value  = {24'd0, entry_a.press_count};
                        wr_data.press_count = '0;
                    end else if (item.mode == MODE_UP_COUNT) begin
                        result.query_value    = {24'd0, entry_a.release_count};
                        wr_data.release_count = '0;
                    end else if (btn_held) begin
                        result.query_value = item.stamp_ms - entry_a.press_time;
                        wr_data.press_time = item.stamp_ms;
                    end else begin
                        result.query_value   = entry_a.release_time - entry_a.press_time;
                        wr_data.press_time   = '0;
                        wr_data.release_time = '0;
                    end
                end
            end
        endcase
    end

    assign wr_en = fire && wr_req;

    // State registers advance only when the item in this stage commits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            delta_x_reg <= '0;
            delta_y_reg <= '0;
            delta_z_reg <= '0;
            accum_reg   <= '0;
            held_reg    <= '0;
        end else if (fire) begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pos_z_reg   <= pos_z_next;
            delta_x_reg <= delta_x_next;
            delta_y_reg <= delta_y_next;
            delta_z_reg <= delta_z_next;
            accum_reg   <= accum_next;
            held_reg    <= held_next;
        end
    end

endmodule
